FILE: src/vlc_pkg.sv
// Shared widths, codes and types for the vector length clamp.
package vlc_pkg;

   localparam int DATA_W  = 32;
   localparam int WIDE_W  = 2 * DATA_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MIN  = 2'd1,
      KIND_MAX  = 2'd2
   } clamp_kind_type;

endpackage

FILE: src/vector_length_clamp_core.sv
// Top level of the vector length clamp: pipeline control, scaling and saturation.
//
// The block takes a 3D vector of signed fixed-point components on the req_
// channel and returns one result transaction on the rsp_ channel for each
// request transaction, in order. The Euclidean length is the truncated
// square root of the exact sum of squares. A nonzero vector shorter than
// min_length is scaled up to it; otherwise a vector longer than max_length
// is scaled down to it. Scaled components saturate to the signed 32-bit
// range and rsp_saturated reports it; rsp_clamp_kind tells which bound hit.
// The bounds are written through the csr_ channel (index 0 minimum, index 1
// maximum); the user must do so only while no transaction is in flight, which the
// block does not enforce. csr_ready is always high. The pipeline has the
// magnitude, squaring and summing registers, a 32-stage square root, compare and
// multiply registers, a 32-stage divider and one output register. One
// transaction enters per cycle unless the receiver stalls with a result waiting;
// the whole pipeline then holds and req_ready drops. Nothing is lost or repeated.
// Reset clears all valid bits and both bounds; no clearing pass is needed.
module vector_length_clamp_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [vlc_pkg::DATA_W-1:0]  req_in_x,
   input  logic signed [vlc_pkg::DATA_W-1:0]  req_in_y,
   input  logic signed [vlc_pkg::DATA_W-1:0]  req_in_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vlc_pkg::DATA_W-1:0]  rsp_out_x,
   output logic signed [vlc_pkg::DATA_W-1:0]  rsp_out_y,
   output logic signed [vlc_pkg::DATA_W-1:0]  rsp_out_z,
   output logic [1:0]                         rsp_clamp_kind,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vlc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vlc_pkg::DATA_W-1:0]         csr_data
);
   import vlc_pkg::*;

   localparam int RAW_W = 3 * DATA_W;
   localparam int DPW   = RAW_W + 2;

   logic en;

   // Configuration registers.
   logic [DATA_W-1:0] min_len_ff, max_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= '0;
         max_len_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_LENGTH: min_len_ff <= csr_data;
            CSR_MAX_LENGTH: max_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline advances as one; it only holds when a finished result
   // sits in the output register and the receiver is not taking it.
   logic vld6_ff;
   assign en        = !vld6_ff || rsp_ready;
   assign req_ready = en;

   // Stage 1: input capture with component magnitudes.
   logic                   vld1_ff;
   logic [RAW_W-1:0]       raw1_ff;
   logic [2:0][DATA_W-1:0] mag1_ff;
   logic [RAW_W-1:0]       raw_in;
   logic [2:0][DATA_W-1:0] mag1_in;

   always_comb begin
      raw_in = {req_in_z, req_in_y, req_in_x};
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = raw_in[i*DATA_W + DATA_W-1]
                    ? DATA_W'(~raw_in[i*DATA_W +: DATA_W] + 1'b1)
                    : raw_in[i*DATA_W +: DATA_W];
      end
   end

   // Stage 2: squares. Stage 3: sum of squares, exact in 64 bits.
   logic                   vld2_ff, vld3_ff;
   logic [RAW_W-1:0]       raw2_ff, raw3_ff;
   logic [2:0][WIDE_W-1:0] sq2_ff;
   logic [WIDE_W-1:0]      sum3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      if (en) begin
         raw1_ff <= raw_in;
         mag1_ff <= mag1_in;
         raw2_ff <= raw1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= WIDE_W'(mag1_ff[i]) * WIDE_W'(mag1_ff[i]);
         end
         raw3_ff <= raw2_ff;
         sum3_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      end
   end

   // Length.
   logic              sq_vld;
   logic [DATA_W-1:0] sq_len;
   logic [RAW_W-1:0]  sq_raw;

   vlc_sqrt #(.PW(RAW_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld3_ff),
      .in_rad    (sum3_ff),
      .in_pay    (raw3_ff),
      .out_valid (sq_vld),
      .out_root  (sq_len),
      .out_pay   (sq_raw)
   );

   // Stage 4: bound tests. The minimum test wins over the maximum test,
   // and a zero vector is never raised.
   logic                   vld4_ff, vld5_ff;
   clamp_kind_type         kind4_ff, kind5_ff, kind4_in;
   logic [DATA_W-1:0]      tgt4_ff, tgt4_in, len4_ff, len5_ff;
   logic [RAW_W-1:0]       raw4_ff, raw5_ff;
   logic [2:0][DATA_W-1:0] mag4_ff, mag4_in;
   logic [2:0][WIDE_W-1:0] prod5_ff;

   always_comb begin
      kind4_in = KIND_NONE;
      tgt4_in  = '0;
      if (sq_len < min_len_ff && sq_len != '0) begin
         kind4_in = KIND_MIN;
         tgt4_in  = min_len_ff;
      end else if (sq_len > max_len_ff) begin
         kind4_in = KIND_MAX;
         tgt4_in  = max_len_ff;
      end
      for (int i = 0; i < 3; i++) begin
         mag4_in[i] = sq_raw[i*DATA_W + DATA_W-1]
                    ? DATA_W'(~sq_raw[i*DATA_W +: DATA_W] + 1'b1)
                    : sq_raw[i*DATA_W +: DATA_W];
      end
   end

   // Stage 5: magnitude times target length.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (en) begin
         vld4_ff <= sq_vld;
         vld5_ff <= vld4_ff;
      end
      if (en) begin
         kind4_ff <= kind4_in;
         tgt4_ff  <= tgt4_in;
         len4_ff  <= sq_len;
         raw4_ff  <= sq_raw;
         mag4_ff  <= mag4_in;
         kind5_ff <= kind4_ff;
         len5_ff  <= len4_ff;
         raw5_ff  <= raw4_ff;
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i] <= WIDE_W'(mag4_ff[i]) * WIDE_W'(tgt4_ff);
         end
      end
   end

   // Scaled magnitudes. The quotient never exceeds the target, so it fits
   // in 32 bits. An unchanged vector divides by whatever length it has,
   // possibly zero, and that quotient is ignored.
   logic                   dv_vld;
   logic [2:0][DATA_W-1:0] dv_quo;
   logic [DPW-1:0]         dv_pay;

   vlc_div #(.PW(DPW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld5_ff),
      .in_num    (prod5_ff),
      .in_den    (len5_ff),
      .in_pay    ({kind5_ff, raw5_ff}),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_pay   (dv_pay)
   );

   // Stage 6: sign restore, saturation and output register.
   logic [RAW_W-1:0] out6_ff, out6_in;
   logic [1:0]       kind6_ff;
   logic             sat6_ff, sat6_in;

   always_comb begin
      logic             neg;
      logic [DATA_W-1:0] q, lim;
      neg     = 1'b0;
      q       = '0;
      lim     = '0;
      sat6_in = 1'b0;
      out6_in = dv_pay[RAW_W-1:0];
      if (clamp_kind_type'(dv_pay[DPW-1:RAW_W]) != KIND_NONE) begin
         for (int i = 0; i < 3; i++) begin
            neg = dv_pay[i*DATA_W + DATA_W-1];
            lim = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            q   = dv_quo[i];
            if (q > lim) begin
               q       = lim;
               sat6_in = 1'b1;
            end
            out6_in[i*DATA_W +: DATA_W] = neg ? DATA_W'(~q + 1'b1) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld6_ff <= dv_vld;
      end
      if (en) begin
         out6_ff  <= out6_in;
         kind6_ff <= dv_pay[DPW-1:RAW_W];
         sat6_ff  <= sat6_in;
      end
   end

   assign rsp_valid      = vld6_ff;
   assign rsp_out_x      = out6_ff[0*DATA_W +: DATA_W];
   assign rsp_out_y      = out6_ff[1*DATA_W +: DATA_W];
   assign rsp_out_z      = out6_ff[2*DATA_W +: DATA_W];
   assign rsp_clamp_kind = kind6_ff;
   assign rsp_saturated  = sat6_ff;

endmodule

FILE: src/vlc_sqrt.sv
// Pipelined truncating square root, one root bit per stage.
module vlc_sqrt #(
   parameter int PW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [vlc_pkg::WIDE_W-1:0]    in_rad,
   input  logic [PW-1:0]                 in_pay,
   output logic                          out_valid,
   output logic [vlc_pkg::DATA_W-1:0]    out_root,
   output logic [PW-1:0]                 out_pay
);
   import vlc_pkg::*;

   localparam int STEPS = DATA_W;
   localparam int REM_W = DATA_W + 3;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic              vld_ff;
      logic [WIDE_W-1:0] rad_ff;
      logic [REM_W-1:0]  rem_ff;
      logic [DATA_W-1:0] root_ff;
      logic [PW-1:0]     pay_ff;
      logic              src_vld;
      logic [WIDE_W-1:0] src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [DATA_W-1:0] src_root;
      logic [PW-1:0]     src_pay;
      logic [REM_W-1:0]  rem_sh, trial;
      logic              ge;

      // The first stage starts from the radicand with a clear remainder.
      if (k == 0) begin : g_src
         assign src_vld  = in_valid;
         assign src_rad  = in_rad;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_pay  = in_pay;
      end else begin : g_src
         assign src_vld  = g_step[k-1].vld_ff;
         assign src_rad  = g_step[k-1].rad_ff;
         assign src_rem  = g_step[k-1].rem_ff;
         assign src_root = g_step[k-1].root_ff;
         assign src_pay  = g_step[k-1].pay_ff;
      end

      always_comb begin
         rem_sh = {src_rem[REM_W-3:0], src_rad[WIDE_W-1 -: 2]};
         trial  = {1'b0, src_root, 2'b01};
         ge     = rem_sh >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= src_vld;
         end
         if (en) begin
            rad_ff  <= src_rad << 2;
            rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff <= {src_root[DATA_W-2:0], ge};
            pay_ff  <= src_pay;
         end
      end
   end

   assign out_valid = g_step[STEPS-1].vld_ff;
   assign out_root  = g_step[STEPS-1].root_ff;
   assign out_pay   = g_step[STEPS-1].pay_ff;

endmodule

FILE: src/vlc_div.sv
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
module vlc_div #(
   parameter int PW = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][vlc_pkg::WIDE_W-1:0]      in_num,
   input  logic [vlc_pkg::DATA_W-1:0]           in_den,
   input  logic [PW-1:0]                        in_pay,
   output logic                                 out_valid,
   output logic [2:0][vlc_pkg::DATA_W-1:0]      out_quo,
   output logic [PW-1:0]                        out_pay
);
   import vlc_pkg::*;

   localparam int STEPS = DATA_W;

   // The quotient is known to fit in DATA_W bits, so the high half of the
   // numerator is already below the divisor and seeds the remainder.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                   vld_ff;
      logic [2:0][DATA_W-1:0] rem_ff;
      logic [2:0][DATA_W-1:0] lo_ff;
      logic [DATA_W-1:0]      den_ff;
      logic [PW-1:0]          pay_ff;
      logic                   src_vld;
      logic [2:0][DATA_W-1:0] src_rem, src_lo;
      logic [DATA_W-1:0]      src_den;
      logic [PW-1:0]          src_pay;
      logic [2:0][DATA_W:0]   rem_sh;
      logic [2:0]             ge;
      logic [2:0][DATA_W-1:0] rem_in, lo_in;

      if (k == 0) begin : g_src
         assign src_vld = in_valid;
         assign src_rem = {in_num[2][WIDE_W-1:DATA_W], in_num[1][WIDE_W-1:DATA_W],
                           in_num[0][WIDE_W-1:DATA_W]};
         assign src_lo  = {in_num[2][DATA_W-1:0], in_num[1][DATA_W-1:0],
                           in_num[0][DATA_W-1:0]};
         assign src_den = in_den;
         assign src_pay = in_pay;
      end else begin : g_src
         assign src_vld = g_step[k-1].vld_ff;
         assign src_rem = g_step[k-1].rem_ff;
         assign src_lo  = g_step[k-1].lo_ff;
         assign src_den = g_step[k-1].den_ff;
         assign src_pay = g_step[k-1].pay_ff;
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem_sh[l] = {src_rem[l], src_lo[l][DATA_W-1]};
            ge[l]     = rem_sh[l] >= {1'b0, src_den};
            rem_in[l] = ge[l] ? DATA_W'(rem_sh[l] - {1'b0, src_den})
                              : rem_sh[l][DATA_W-1:0];
            lo_in[l]  = {src_lo[l][DATA_W-2:0], ge[l]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= src_vld;
         end
         if (en) begin
            rem_ff <= rem_in;
            lo_ff  <= lo_in;
            den_ff <= src_den;
            pay_ff <= src_pay;
         end
      end
   end

   assign out_valid = g_step[STEPS-1].vld_ff;
   assign out_quo   = g_step[STEPS-1].lo_ff;
   assign out_pay   = g_step[STEPS-1].pay_ff;

endmodule
